[src/assert_macros.svh]
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante true at a clock edge implies cons at the same edge
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// expr must never hold at a clock edge
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[src/stc_pkg.sv]
package stc_pkg;

    localparam int POS_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RES         = 6;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_MINUS,
        MODE_STRING
    } mode_t;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    localparam logic [2:0] KIND_BEGIN = 3'd0;
    localparam logic [2:0] KIND_CHAR  = 3'd1;
    localparam logic [2:0] KIND_END   = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    localparam logic [1:0] TK_IDENT = 2'd0;
    localparam logic [1:0] TK_INT   = 2'd1;
    localparam logic [1:0] TK_STR   = 2'd2;
    localparam logic [1:0] TK_SYM   = 2'd3;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_UNTERM     = 2'd2;
    localparam logic [1:0] ERR_BAD_ESCAPE = 2'd3;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_NUL       = 8'h00;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  token_kind;
        logic [7:0]  value_char;
        logic [1:0]  error_code;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        last_of_run;
    } out_t;

    // one result of a plan; line is shared by all results of the item
    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] token_kind;
        logic [7:0] value_char;
        logic [1:0] error_code;
        logic       use_minus_col;
    } rec_t;

    typedef logic [2:0] res_cnt_t;

    typedef struct packed {
        res_cnt_t                cnt;
        rec_t [MAX_RES-1:0]      recs;
        logic [15:0]             line;
        logic [15:0]             col;
        logic [15:0]             minus_col;
    } plan_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } esc_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        logic r;
        case (c)
            "[", "]", "-", ">", "<", "{", "}", ":", "+", "!",
            "=", "*", "/", "%", ";", "(", ")", ".", ",": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic esc_t decode_escape(input logic [7:0] c);
        esc_t e;
        e.ok = 1'b1;
        case (c)
            "n":  e.value = 8'h0A;
            "t":  e.value = 8'h09;
            "r":  e.value = 8'h0D;
            "\\": e.value = CH_BACKSLASH;
            "\"": e.value = CH_QUOTE;
            "'":  e.value = 8'h27;
            "0":  e.value = CH_NUL;
            default: begin
                e.ok    = 1'b0;
                e.value = CH_NUL;
            end
        endcase
        return e;
    endfunction

    function automatic rec_t mk_rec(input logic [2:0] kind, input logic [1:0] tk,
                                    input logic [7:0] ch, input logic [1:0] err,
                                    input logic use_m);
        rec_t r;
        r.kind          = kind;
        r.token_kind    = tk;
        r.value_char    = ch;
        r.error_code    = err;
        r.use_minus_col = use_m;
        return r;
    endfunction

endpackage

[src/stc_front.sv]
module stc_front
    import stc_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  in_t   s_data,
    input  logic  q_full,
    output logic  q_push,
    output plan_t q_plan
);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    mode_t               mode_reg, mode_next;
    logic                esc_reg, esc_next;
    logic                pbs_reg, pbs_next;
    logic [1:0]          err_reg, err_next;
    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic [POS_BITS-1:0] mcol_reg, mcol_next;

    logic       accept;
    logic [7:0] c;
    logic       c_alpha, c_digit, c_space, c_symbol;
    esc_t       esc;
    logic       start_tok;
    res_cnt_t   n;
    plan_t      plan;

    assign c        = s_data.char_code;
    assign c_alpha  = is_alpha(c);
    assign c_digit  = is_digit(c);
    assign c_space  = is_space(c);
    assign c_symbol = is_symbol(c);
    assign esc      = decode_escape(c);

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (plan.cnt != '0);
    assign q_plan  = plan;

    always_comb begin : next_state
        mode_next = mode_reg;
        esc_next  = esc_reg;
        pbs_next  = pbs_reg;
        err_next  = err_reg;
        mcol_next = mcol_reg;
        line_next = line_reg;
        col_next  = col_reg;
        start_tok = 1'b0;
        if (s_data.cmd == CMD_EOS) begin
            mode_next = MODE_IDLE;
            esc_next  = 1'b0;
            pbs_next  = 1'b0;
            err_next  = ERR_NONE;
            mcol_next = POS_ONE;
            line_next = POS_ONE;
            col_next  = POS_ONE;
        end else begin
            if (err_reg == ERR_NONE) begin
                case (mode_reg)
                    MODE_IDENT: start_tok = !(c_alpha || c_digit);
                    MODE_INT:   start_tok = !c_digit;
                    MODE_MINUS: begin
                        if (c_digit) begin
                            mode_next = MODE_INT;
                        end else begin
                            start_tok = 1'b1;
                        end
                    end
                    MODE_STRING: begin
                        if (esc_reg) begin
                            if (esc.ok) begin
                                esc_next = 1'b0;
                                pbs_next = (c == CH_BACKSLASH);
                            end else begin
                                err_next  = ERR_BAD_ESCAPE;
                                mode_next = MODE_IDLE;
                                esc_next  = 1'b0;
                                pbs_next  = 1'b0;
                            end
                        end else if (c == CH_QUOTE && !pbs_reg) begin
                            mode_next = MODE_IDLE;
                            pbs_next  = 1'b0;
                        end else if (c == CH_BACKSLASH) begin
                            esc_next = 1'b1;
                            pbs_next = 1'b1;
                        end else begin
                            pbs_next = 1'b0;
                        end
                    end
                    default: start_tok = 1'b1;
                endcase
                if (start_tok) begin
                    if (c_alpha) begin
                        mode_next = MODE_IDENT;
                    end else if (c_digit) begin
                        mode_next = MODE_INT;
                    end else if (c == CH_MINUS) begin
                        mode_next = MODE_MINUS;
                        mcol_next = col_reg;
                    end else if (c == CH_QUOTE) begin
                        mode_next = MODE_STRING;
                        esc_next  = 1'b0;
                        pbs_next  = 1'b0;
                    end else if (c_symbol || c_space) begin
                        mode_next = MODE_IDLE;
                    end else begin
                        err_next  = ERR_UNEXPECTED;
                        mode_next = MODE_IDLE;
                        esc_next  = 1'b0;
                        pbs_next  = 1'b0;
                    end
                end
            end
            // newline inside an open string is just a string character
            if (c == CH_NEWLINE && !(err_next == ERR_NONE && mode_next == MODE_STRING)) begin
                if (line_reg != POS_MAX) begin
                    line_next = line_reg + POS_ONE;
                end
                col_next = POS_ONE;
            end else if (col_reg != POS_MAX) begin
                col_next = col_reg + POS_ONE;
            end
        end
    end

    always_comb begin : plan_out
        plan           = '0;
        n              = '0;
        plan.line      = 16'(line_reg);
        plan.col       = 16'(col_reg);
        plan.minus_col = 16'(mcol_reg);
        if (s_data.cmd == CMD_EOS) begin
            if (err_reg == ERR_NONE) begin
                case (mode_reg)
                    MODE_IDENT: begin
                        plan.recs[n] = mk_rec(KIND_END, TK_IDENT, CH_NUL, ERR_NONE, 1'b0);
                        n = n + 3'd1;
                    end
                    MODE_INT: begin
                        plan.recs[n] = mk_rec(KIND_END, TK_INT, CH_NUL, ERR_NONE, 1'b0);
                        n = n + 3'd1;
                    end
                    MODE_MINUS: begin
                        plan.recs[n] = mk_rec(KIND_BEGIN, TK_SYM, CH_NUL, ERR_NONE, 1'b1);
                        n = n + 3'd1;
                        plan.recs[n] = mk_rec(KIND_CHAR, TK_SYM, CH_MINUS, ERR_NONE, 1'b1);
                        n = n + 3'd1;
                        plan.recs[n] = mk_rec(KIND_END, TK_SYM, CH_NUL, ERR_NONE, 1'b1);
                        n = n + 3'd1;
                    end
                    MODE_STRING: begin
                        plan.recs[n] = mk_rec(KIND_ERROR, TK_IDENT, CH_NUL, ERR_UNTERM, 1'b0);
                        n = n + 3'd1;
                    end
                    default: ;
                endcase
            end
            plan.recs[n] = mk_rec(KIND_DONE, TK_IDENT, CH_NUL,
                                  (err_reg == ERR_NONE && mode_reg == MODE_STRING) ?
                                  ERR_UNTERM : err_reg, 1'b0);
            n = n + 3'd1;
        end else if (err_reg == ERR_NONE) begin
            case (mode_reg)
                MODE_IDENT: begin
                    if (c_alpha || c_digit) begin
                        plan.recs[n] = mk_rec(KIND_CHAR, TK_IDENT, c, ERR_NONE, 1'b0);
                    end else begin
                        plan.recs[n] = mk_rec(KIND_END, TK_IDENT, CH_NUL, ERR_NONE, 1'b0);
                    end
                    n = n + 3'd1;
                end
                MODE_INT: begin
                    if (c_digit) begin
                        plan.recs[n] = mk_rec(KIND_CHAR, TK_INT, c, ERR_NONE, 1'b0);
                    end else begin
                        plan.recs[n] = mk_rec(KIND_END, TK_INT, CH_NUL, ERR_NONE, 1'b0);
                    end
                    n = n + 3'd1;
                end
                MODE_MINUS: begin
                    // held minus resolves here: integer sign or stand-alone symbol
                    if (c_digit) begin
                        plan.recs[n] = mk_rec(KIND_BEGIN, TK_INT, CH_NUL, ERR_NONE, 1'b1);
                        n = n + 3'd1;
                        plan.recs[n] = mk_rec(KIND_CHAR, TK_INT, CH_MINUS, ERR_NONE, 1'b1);
                        n = n + 3'd1;
                        plan.recs[n] = mk_rec(KIND_CHAR, TK_INT, c, ERR_NONE, 1'b0);
                        n = n + 3'd1;
                    end else begin
                        plan.recs[n] = mk_rec(KIND_BEGIN, TK_SYM, CH_NUL, ERR_NONE, 1'b1);
                        n = n + 3'd1;
                        plan.recs[n] = mk_rec(KIND_CHAR, TK_SYM, CH_MINUS, ERR_NONE, 1'b1);
                        n = n + 3'd1;
                        plan.recs[n] = mk_rec(KIND_END, TK_SYM, CH_NUL, ERR_NONE, 1'b1);
                        n = n + 3'd1;
                    end
                end
                MODE_STRING: begin
                    if (esc_reg) begin
                        if (esc.ok) begin
                            plan.recs[n] = mk_rec(KIND_CHAR, TK_STR, esc.value, ERR_NONE, 1'b0);
                        end else begin
                            plan.recs[n] = mk_rec(KIND_ERROR, TK_IDENT, CH_NUL,
                                                  ERR_BAD_ESCAPE, 1'b0);
                        end
                        n = n + 3'd1;
                    end else if (c == CH_QUOTE && !pbs_reg) begin
                        plan.recs[n] = mk_rec(KIND_END, TK_STR, CH_NUL, ERR_NONE, 1'b0);
                        n = n + 3'd1;
                    end else if (c != CH_BACKSLASH) begin
                        plan.recs[n] = mk_rec(KIND_CHAR, TK_STR, c, ERR_NONE, 1'b0);
                        n = n + 3'd1;
                    end
                end
                default: ;
            endcase
            if (start_tok) begin
                if (c_alpha) begin
                    plan.recs[n] = mk_rec(KIND_BEGIN, TK_IDENT, CH_NUL, ERR_NONE, 1'b0);
                    n = n + 3'd1;
                    plan.recs[n] = mk_rec(KIND_CHAR, TK_IDENT, c, ERR_NONE, 1'b0);
                    n = n + 3'd1;
                end else if (c_digit) begin
                    plan.recs[n] = mk_rec(KIND_BEGIN, TK_INT, CH_NUL, ERR_NONE, 1'b0);
                    n = n + 3'd1;
                    plan.recs[n] = mk_rec(KIND_CHAR, TK_INT, c, ERR_NONE, 1'b0);
                    n = n + 3'd1;
                end else if (c == CH_MINUS) begin
                    n = n;
                end else if (c == CH_QUOTE) begin
                    plan.recs[n] = mk_rec(KIND_BEGIN, TK_STR, CH_NUL, ERR_NONE, 1'b0);
                    n = n + 3'd1;
                end else if (c_symbol) begin
                    plan.recs[n] = mk_rec(KIND_BEGIN, TK_SYM, CH_NUL, ERR_NONE, 1'b0);
                    n = n + 3'd1;
                    plan.recs[n] = mk_rec(KIND_CHAR, TK_SYM, c, ERR_NONE, 1'b0);
                    n = n + 3'd1;
                    plan.recs[n] = mk_rec(KIND_END, TK_SYM, CH_NUL, ERR_NONE, 1'b0);
                    n = n + 3'd1;
                end else if (!c_space) begin
                    plan.recs[n] = mk_rec(KIND_ERROR, TK_IDENT, CH_NUL, ERR_UNEXPECTED, 1'b0);
                    n = n + 3'd1;
                end
            end
        end
        plan.cnt = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            esc_reg  <= 1'b0;
            pbs_reg  <= 1'b0;
            err_reg  <= ERR_NONE;
            line_reg <= POS_ONE;
            col_reg  <= POS_ONE;
            mcol_reg <= POS_ONE;
        end else if (accept) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            pbs_reg  <= pbs_next;
            err_reg  <= err_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            mcol_reg <= mcol_next;
        end
    end

endmodule

[src/stc_queue.sv]
module stc_queue
    import stc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  plan_t push_plan,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output plan_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    plan_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_plan;
        end
    end

endmodule

[src/stc_back.sv]
module stc_back
    import stc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  head_valid,
    input  plan_t head,
    output logic  pop,
    output logic  m_valid,
    input  logic  m_ready,
    output out_t  m_data
);

    res_cnt_t idx_reg, idx_next;
    logic     m_valid_reg, m_valid_next;
    out_t     m_data_reg, m_data_next;

    logic out_free;
    logic load;
    logic last;
    rec_t rec;

    assign out_free = !m_valid_reg || m_ready;
    assign load     = head_valid && out_free;
    assign rec      = head.recs[idx_reg];
    assign last     = (idx_reg == head.cnt - 3'd1);
    assign pop      = load && last;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            idx_next     = last ? '0 : idx_reg + 3'd1;
            m_valid_next = 1'b1;
        end
    end

    always_comb begin
        m_data_next.kind          = rec.kind;
        m_data_next.token_kind    = rec.token_kind;
        m_data_next.value_char    = rec.value_char;
        m_data_next.error_code    = rec.error_code;
        m_data_next.line_number   = head.line;
        m_data_next.column_number = rec.use_minus_col ? head.minus_col : head.col;
        m_data_next.last_of_run   = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

[src/source_char_tokenizer_unit.sv]
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    in_t  {cmd, char_code}
// m_        out  m_valid/m_ready    out_t {kind .. last_of_run}
//
// Front takes one beat per cycle while the plan queue has room; the back end
// sends one result per cycle while m_ready does not hold the output back.
// A beat's first result is written to the plan queue, then to the output register.
// aresetn (synchronous) empties the queue and the output register and sets
// line and column to 1.
// A stalled m_ channel fills the QUEUE_DEPTH-entry queue, then drops s_ready.
`include "assert_macros.svh"

module source_char_tokenizer_unit
    import stc_pkg::*;
#(
    parameter int POS_BITS    = POS_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_head_valid;
    plan_t q_plan;
    plan_t q_head;

    stc_front #(
        .POS_BITS(POS_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_plan  (q_plan)
    );

    stc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_plan  (q_plan),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    stc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    `ASSERT_IMPLIES(a_done_is_last, aclk, aresetn, m_valid && m_data.kind == KIND_DONE, m_data.last_of_run, "source done result is not last of its run")
    `ASSERT_IMPLIES(a_error_has_code, aclk, aresetn, m_valid && m_data.kind == KIND_ERROR, m_data.error_code != ERR_NONE, "error result without error code")
    `ASSERT_NEVER(a_mark_no_char, aclk, aresetn, m_valid && (m_data.kind == KIND_BEGIN || m_data.kind == KIND_END) && m_data.value_char != CH_NUL, "begin or end mark carries a character")

endmodule
